// ===== hw/rtl/dsmf_pkg.sv =====
// Shared constants and types for the dual sliding-window median filter.
`timescale 1ns / 1ps

package dsmf_pkg;

    // Window geometry and sample width
    localparam int WINDOW_LEN  = 21;
    localparam int SAMPLE_BITS = 10;

    // Derived sizes
    localparam int POS_BITS   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CNT_BITS   = $clog2(WINDOW_LEN + 1);
    localparam int TARGET     = (WINDOW_LEN - 1) / 2;
    localparam int TDATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int PAD_BITS   = TDATA_BITS - 2 * SAMPLE_BITS;

    localparam logic [POS_BITS-1:0] LAST_POS   = POS_BITS'(WINDOW_LEN - 1);
    localparam logic [CNT_BITS-1:0] TARGET_CNT = CNT_BITS'(TARGET);

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] window_t;

endpackage

// ===== hw/rtl/dsmf_rank_lane.sv =====
// One rank lane: ranks a single window entry against the whole window.
`timescale 1ns / 1ps

module dsmf_rank_lane
    import dsmf_pkg::*;
(
    input  sample_t own_value,
    input  window_t win,
    output logic    hit
);

    logic [WINDOW_LEN-1:0] above_vec;
    logic [WINDOW_LEN-1:0] atleast_vec;
    logic [CNT_BITS-1:0]   above_cnt;
    logic [CNT_BITS-1:0]   atleast_cnt;

    // Compare against every entry, independent per entry
    always_comb begin
        for (int b = 0; b < WINDOW_LEN; b++) begin
            above_vec[b]   = (win[b] >  own_value);
            atleast_vec[b] = (win[b] >= own_value);
        end
    end

    assign above_cnt   = CNT_BITS'($countones(above_vec));
    assign atleast_cnt = CNT_BITS'($countones(atleast_vec));

    // Entry sits at the middle position of the descending order
    assign hit = (above_cnt <= TARGET_CNT) && (atleast_cnt > TARGET_CNT);

endmodule

// ===== hw/rtl/dsmf_channel_median.sv =====
// Median of one window: a rank lane per entry and a merge of the hits.
`timescale 1ns / 1ps

module dsmf_channel_median
    import dsmf_pkg::*;
(
    input  window_t win,
    output sample_t median
);

    logic [WINDOW_LEN-1:0] hit_vec;

    // One lane per window entry
    for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_lane
        dsmf_rank_lane u_lane (
            .own_value (win[g]),
            .win       (win),
            .hit       (hit_vec[g])
        );
    end

    // Merge: every hitting entry holds the same value, so OR them together
    always_comb begin
        median = '0;
        for (int a = 0; a < WINDOW_LEN; a++) begin
            if (hit_vec[a]) begin
                median = median | win[a];
            end
        end
    end

endmodule

// ===== hw/rtl/dual_sliding_median_filter_top.sv =====
// Top level of the dual sliding-window median filter with stream ports.
`timescale 1ns / 1ps

// Each transaction on the s_ side carries one voltage and one current sample;
// each overwrites the oldest entry of its own 21-entry window (both windows
// start at zero after reset, so those zeros count until the windows fill),
// and exactly one m_ transaction follows with the median of each window.
// The block takes one transaction per clock while the output is not stalled;
// a result reaches m_tvalid through two registers: the accepting edge writes
// the windows, the parallel compare lanes rank every entry combinationally,
// and the output register loads once it is free. s_tready drops only while a
// ranked window waits behind a stalled output register.
module dual_sliding_median_filter_top
    import dsmf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: [9:0] voltage_sample, [19:10] current_sample, rest zero
    input  logic [TDATA_BITS-1:0] s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // m_tdata: [9:0] voltage_median, [19:10] current_median, rest zero
    output logic [TDATA_BITS-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready
);

    window_t              volt_win_reg;
    window_t              curr_win_reg;
    logic [POS_BITS-1:0]  pos_reg;
    logic [POS_BITS-1:0]  pos_next;
    logic                 win_valid_reg;
    logic                 win_valid_next;
    sample_t              volt_med_reg;
    sample_t              curr_med_reg;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    sample_t              volt_med;
    sample_t              curr_med;
    logic                 s_accept;
    logic                 out_load;

    // Handshake control
    assign out_load = win_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !win_valid_reg || out_load;
    assign s_accept = s_tvalid && s_tready;

    assign pos_next       = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
    assign win_valid_next = s_accept ? 1'b1 : (out_load ? 1'b0 : win_valid_reg);
    assign m_valid_next   = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    // Circular windows and write position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volt_win_reg  <= '0;
            curr_win_reg  <= '0;
            pos_reg       <= '0;
            win_valid_reg <= 1'b0;
        end else begin
            win_valid_reg <= win_valid_next;
            if (s_accept) begin
                volt_win_reg[pos_reg] <= s_tdata[SAMPLE_BITS-1:0];
                curr_win_reg[pos_reg] <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
                pos_reg               <= pos_next;
            end
        end
    end

    // Ranking lanes, one set per channel
    dsmf_channel_median u_volt_median (
        .win    (volt_win_reg),
        .median (volt_med)
    );

    dsmf_channel_median u_curr_median (
        .win    (curr_win_reg),
        .median (curr_med)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            volt_med_reg <= volt_med;
            curr_med_reg <= curr_med;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_BITS{1'b0}}, curr_med_reg, volt_med_reg};

endmodule

// ===== hw/rtl/dsmf_checker.sv =====
// Port-level checks for the median filter, bound to the top level.
`timescale 1ns / 1ps

module dsmf_checker
    import dsmf_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic [TDATA_BITS-1:0] m_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready
);

    // A pending result is held until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped before transaction completed");

    // Stalled result data holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // Input stalls only behind a stalled output
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("s_tready low without output backpressure");

    // Reset empties the output
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set right after reset");

    // Pad bits of the result stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata >> (2 * SAMPLE_BITS)) == '0)
        else $error("m_tdata pad bits not zero");

endmodule

bind dual_sliding_median_filter_top dsmf_checker u_dsmf_checker (.*);

// ===== tb/tb_dual_sliding_median_filter_top.sv =====
// Self-checking testbench for the dual sliding-window median filter top level.
`timescale 1ns / 1ps

module tb_dual_sliding_median_filter_top;
    import dsmf_pkg::*;

    localparam int DIRECTED_ITEMS = 25;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int MAX_GAP        = 14;
    localparam int HOLD_AFTER     = 300;     // results seen before the long output hold
    localparam int HOLD_CYCLES    = 120;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 400000;

    typedef enum int {
        KIND_UNIFORM,
        KIND_NOISY,
        KIND_EXTREMES,
        KIND_FEW
    } stim_kind_t;

    // Tracks both windows and the queue of median pairs still owed by the block
    class median_scoreboard_t;
        window_t     volt_window;
        window_t     curr_window;
        int unsigned wr_slot;
        sample_t     pending_volt_medians[$];
        sample_t     pending_curr_medians[$];
        int unsigned mismatches;
        int unsigned checked;

        function new();
            volt_window = '0;
            curr_window = '0;
            wr_slot     = 0;
            mismatches  = 0;
            checked     = 0;
        endfunction

        // Descending sort, then take the middle slot
        function sample_t window_median(window_t w);
            sample_t sorted [WINDOW_LEN];
            sample_t tmp;
            int      j;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                sorted[i] = w[i];
            end
            for (int i = 1; i < WINDOW_LEN; i++) begin
                tmp = sorted[i];
                j   = i - 1;
                while (j >= 0 && sorted[j] < tmp) begin
                    sorted[j + 1] = sorted[j];
                    j--;
                end
                sorted[j + 1] = tmp;
            end
            return sorted[TARGET];
        endfunction

        // Accepted input: overwrite oldest slot, advance, queue the new medians
        function void note_samples(sample_t volt, sample_t curr);
            volt_window[wr_slot] = volt;
            curr_window[wr_slot] = curr;
            wr_slot = (wr_slot == WINDOW_LEN - 1) ? 0 : wr_slot + 1;
            pending_volt_medians.push_back(window_median(volt_window));
            pending_curr_medians.push_back(window_median(curr_window));
        endfunction

        function int unsigned pending();
            return pending_volt_medians.size();
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_medians(sample_t volt, sample_t curr);
            sample_t want_volt;
            sample_t want_curr;
            if (pending_volt_medians.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected", checked));
            end else begin
                want_volt = pending_volt_medians.pop_front();
                want_curr = pending_curr_medians.pop_front();
                if (volt !== want_volt)
                    report_mismatch($sformatf("result %0d voltage_median got %0d want %0d",
                                              checked, volt, want_volt));
                if (curr !== want_curr)
                    report_mismatch($sformatf("result %0d current_median got %0d want %0d",
                                              checked, curr, want_curr));
            end
            checked++;
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic [TDATA_BITS-1:0] s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TDATA_BITS-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;

    median_scoreboard_t sb;
    int unsigned        accepted_inputs;
    int unsigned        cycle_count;
    bit                 tx_eager;
    bit                 rx_eager;
    bit                 rx_holding;
    bit                 hold_done;

    dual_sliding_median_filter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // 20 ns clock, first rising edge after the testbench has initialized
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, sb.pending());
            $display("FAIL dual_sliding_median_filter_top");
            $finish;
        end
    end

    // Input monitor: every accepted transaction feeds the predictor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_samples(s_tdata[SAMPLE_BITS-1:0], s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
            accepted_inputs++;
        end
    end

    // Output monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_medians(m_tdata[SAMPLE_BITS-1:0], m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    end

    // Idle cycles before one transaction; eager phases never wait
    function automatic int unsigned draw_gap(bit eager);
        if (eager || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Offer one sample pair and hold it until taken; called and returns at a falling edge
    task automatic send_samples(input sample_t volt, input sample_t curr);
        int unsigned gap;
        gap = draw_gap(tx_eager || rx_holding);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= TDATA_BITS'({curr, volt});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic sample_t pick_sample(stim_kind_t kind, sample_t level,
                                            sample_t few_a, sample_t few_b);
        int v;
        case (kind)
            KIND_NOISY: begin
                v = int'(level) + $urandom_range(0, 40) - 20;
                if (v < 0) v = 0;
                if (v > (1 << SAMPLE_BITS) - 1) v = (1 << SAMPLE_BITS) - 1;
                return sample_t'(v);
            end
            KIND_EXTREMES: begin
                return $urandom_range(0, 1) ? '1 : '0;
            end
            KIND_FEW: begin
                case ($urandom_range(0, 2))
                    0:       return few_a;
                    1:       return few_b;
                    default: return level;
                endcase
            end
            default: begin
                return sample_t'($urandom);
            end
        endcase
    endfunction

    // Receiver: random back-pressure plus one long hold to fill the pipeline
    initial begin
        int unsigned gap;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (!hold_done && sb.checked >= HOLD_AFTER) begin
                hold_done  = 1'b1;
                rx_holding = 1'b1;
                m_tready  <= 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++) @(negedge aclk);
                rx_holding = 1'b0;
            end else begin
                gap = draw_gap(rx_eager);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // Stimulus and end of run
    initial begin
        stim_kind_t  kind;
        sample_t     level;
        sample_t     few_a;
        sample_t     few_b;
        int unsigned phase_len;
        int unsigned sent;
        int unsigned phases;

        sb              = new();
        accepted_inputs = 0;
        cycle_count     = 0;
        tx_eager        = 1'b0;
        rx_eager        = 1'b0;
        rx_holding      = 1'b0;
        hold_done       = 1'b0;
        sent            = 0;
        phases          = 0;
        aresetn         = 1'b0;
        s_tdata         = '0;
        s_tvalid        = 1'b0;
        m_tready        = 1'b0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: extremes, alternating bits, then a fill past the window wrap
        send_samples('0, '0);
        send_samples('1, '1);
        send_samples('1, '0);
        send_samples('0, '1);
        send_samples(sample_t'('h155), sample_t'('h2AA));
        send_samples(sample_t'('h2AA), sample_t'('h155));
        for (int i = 0; i < DIRECTED_ITEMS - 6; i++) begin
            send_samples(sample_t'((1 << SAMPLE_BITS) - 1 - i), sample_t'(1 << (i % SAMPLE_BITS)));
        end
        sent = DIRECTED_ITEMS;

        // Random phases with varied signal shape and idling
        while (sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            kind      = stim_kind_t'($urandom_range(0, 3));
            level     = sample_t'($urandom);
            few_a     = sample_t'($urandom);
            few_b     = sample_t'($urandom);
            phase_len = $urandom_range(40, 160);
            tx_eager  = ($urandom_range(0, 3) == 0);
            rx_eager  = ($urandom_range(0, 3) == 0);
            phases++;
            for (int i = 0; i < phase_len && sent < DIRECTED_ITEMS + RANDOM_ITEMS; i++) begin
                if (kind == KIND_NOISY && $urandom_range(0, 30) == 0)
                    level = sample_t'($urandom);
                send_samples(pick_sample(kind, level, few_a, few_b),
                             pick_sample(kind, level ^ few_a, few_b, few_a));
                sent++;
            end
        end
        s_tvalid <= 1'b0;
        rx_eager  = 1'b1;

        // Drain outstanding results, then let the pipeline settle
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));

        $display("Run covered %0d input transactions (%0d directed, %0d random phases)",
                 accepted_inputs, DIRECTED_ITEMS, phases);
        $display("Checked %0d median pairs, output hold of %0d cycles %0s, %0d mismatches",
                 sb.checked, HOLD_CYCLES, hold_done ? "applied" : "not reached", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("PASS dual_sliding_median_filter_top");
        end else begin
            $display("FAIL dual_sliding_median_filter_top");
        end
        $finish;
    end

endmodule
